// ===== hw/rtl/fcc_pkg.sv =====
// FAT12 cluster chain reader: shared types and constants.
// Request and result payload structs, request and status codes.
// No dependencies.
package fcc_pkg;

  localparam int SECTOR_BYTES = 512;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_WALK  = 2'd1;
  localparam logic [1:0] STATUS_BROKEN   = 2'd2;

  localparam logic [11:0] FREE_ENTRY = 12'h000;
  localparam logic [11:0] BAD_ENTRY  = 12'hFF7;
  localparam logic [11:0] END_FIRST  = 12'hFF8;

  localparam logic [15:0] OFFSET_RESET = 16'd31;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] start_cluster;
    logic [31:0] file_size;
  } req_t;

  typedef struct packed {
    logic [16:0] sector_number;
    logic [9:0]  byte_count;
    logic        last_flag;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ===== hw/rtl/fcc_table.sv =====
// FAT12 cluster chain reader: table byte store in two banks (even, odd bytes).
// One byte written per cycle; two adjacent bytes read per cycle from registered bank outputs.
// No dependencies.
module fcc_table #(
  parameter int TABLE_BYTES = 6144
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [12:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        rd_en,
  input  logic [12:0] rd_off,
  output logic [7:0]  rd_lo,
  output logic [7:0]  rd_hi
);

  localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam logic [13:0] LIMIT = 14'(TABLE_BYTES);

  logic [7:0] even_bank [BANK_DEPTH];
  logic [7:0] odd_bank  [BANK_DEPTH];

  logic [11:0] wr_row;
  logic [13:0] hi_off;
  logic [12:0] even_row;
  logic [11:0] odd_row;
  logic        wr_in_range;

  logic [7:0] even_q;
  logic [7:0] odd_q;
  logic       par_q;
  logic       lo_oob_q;
  logic       hi_oob_q;

  assign wr_row      = wr_addr[12:1];
  assign wr_in_range = {1'b0, wr_addr} < LIMIT;
  assign hi_off      = {1'b0, rd_off} + 14'd1;
  // the even bank row is the offset halved and rounded up, the odd bank row the offset halved and rounded down
  assign even_row    = hi_off[13:1];
  assign odd_row     = rd_off[12:1];

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      if (wr_addr[0]) begin
        odd_bank[wr_row[BANK_AW-1:0]] <= wr_data;
      end else begin
        even_bank[wr_row[BANK_AW-1:0]] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_q   <= even_bank[even_row[BANK_AW-1:0]];
      odd_q    <= odd_bank[odd_row[BANK_AW-1:0]];
      par_q    <= rd_off[0];
      lo_oob_q <= {1'b0, rd_off} >= LIMIT;
      hi_oob_q <= hi_off >= LIMIT;
    end
  end

  // bytes past the table end read as zero
  assign rd_lo = lo_oob_q ? 8'd0 : (par_q ? odd_q : even_q);
  assign rd_hi = hi_oob_q ? 8'd0 : (par_q ? even_q : odd_q);

endmodule

// ===== hw/rtl/fat12_cluster_chain_reader_unit.sv =====
// FAT12 cluster chain reader, top level.
// Depends on fcc_pkg (types, codes) and fcc_table (banked table store).
//
// The unit keeps a copy of a FAT12 allocation table, loaded one byte per load
// request, and walks a file's cluster chain. A start request gives the first
// cluster and the file size and returns that cluster's data sector
// (cluster + data_sector_offset) with the byte count min(512, bytes left).
// Each advance request reads the packed 12-bit entry of the current cluster,
// moves to it and returns the next sector the same way; the result that uses
// up the file carries last_flag. An advance without an active walk returns
// status 1; a free, bad or end-of-chain entry met early returns status 2 and
// ends the walk. A load, a start or an advance with no active walk is handled in
// the idle state; an advance during a walk also passes through the lookup
// state, which takes the entry from the registered read of the table store, which reads
// both bytes of an entry in one access from its even and odd banks. Table bytes
// have no reset and must be loaded before a walk reads them; there is no
// clearing pass. Loads are taken while a result waits on the output; start
// and advance requests wait until the output register is free or drains.
module fat12_cluster_chain_reader_unit #(
  parameter int TABLE_BYTES = 6144
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fcc_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fcc_pkg::rsp_t  rsp,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t        state;
  logic [11:0]   current_cluster;
  logic [31:0]   bytes_remaining;
  logic          walk_active;
  logic [15:0]   data_sector_offset;

  logic          rsp_free;
  logic          needs_slot;
  logic          accept;
  logic          is_load;
  logic          is_start;
  logic          is_advance;
  logic          rsp_load;

  logic [12:0]   entry_off;
  logic [7:0]    tbl_lo;
  logic [7:0]    tbl_hi;
  logic [11:0]   next_entry;
  logic          chain_broken;

  // sector emission for whichever cluster and byte budget is selected
  logic [11:0]   emit_cluster;
  logic [31:0]   emit_remaining;
  logic [9:0]    emit_take;
  logic [31:0]   remaining_next;
  logic [16:0]   emit_sector;

  assign is_load    = req.req_type == fcc_pkg::REQ_LOAD;
  assign is_start   = req.req_type == fcc_pkg::REQ_START;
  assign is_advance = req.req_type == fcc_pkg::REQ_ADVANCE;

  // hold start and advance requests until the output slot is free or draining
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign needs_slot = is_start || is_advance;
  assign req_ready  = (state == ST_IDLE) && (rsp_free || !needs_slot);
  assign accept     = req_valid && req_ready;

  // a result is written by a start, by an advance with no walk, or when a lookup ends
  assign rsp_load = (state == ST_LOOKUP) ||
                    (accept && (is_start || (is_advance && !walk_active)));

  // entry c starts at byte 3c/2 = c + c/2
  assign entry_off = {1'b0, current_cluster} + {2'b00, current_cluster[11:1]};

  fcc_table #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (accept && is_load),
    .wr_addr (req.byte_index),
    .wr_data (req.byte_value),
    .rd_en   (accept && is_advance && walk_active),
    .rd_off  (entry_off),
    .rd_lo   (tbl_lo),
    .rd_hi   (tbl_hi)
  );

  // unpack the 12-bit entry: even clusters take the low nibble of the high byte
  assign next_entry = current_cluster[0] ? {tbl_hi, tbl_lo[7:4]}
                                         : {tbl_hi[3:0], tbl_lo};
  assign chain_broken = (next_entry == fcc_pkg::FREE_ENTRY) ||
                        (next_entry == fcc_pkg::BAD_ENTRY) ||
                        (next_entry >= fcc_pkg::END_FIRST);

  always_comb begin
    if (state == ST_LOOKUP) begin
      emit_cluster   = next_entry;
      emit_remaining = bytes_remaining;
    end else begin
      emit_cluster   = req.start_cluster;
      emit_remaining = req.file_size;
    end
    if (emit_remaining < 32'(fcc_pkg::SECTOR_BYTES)) begin
      emit_take = emit_remaining[9:0];
    end else begin
      emit_take = 10'(fcc_pkg::SECTOR_BYTES);
    end
    remaining_next = emit_remaining - {22'd0, emit_take};
    emit_sector    = {5'd0, emit_cluster} + {1'b0, data_sector_offset};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      current_cluster    <= '0;
      bytes_remaining    <= '0;
      walk_active        <= 1'b0;
      data_sector_offset <= fcc_pkg::OFFSET_RESET;
      rsp_valid          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        data_sector_offset <= cfg_wr_data;
      end
      // raise valid for a new result, drop it once the waiting one is taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && is_start) begin
            current_cluster         <= req.start_cluster;
            bytes_remaining         <= remaining_next;
            walk_active             <= remaining_next != 32'd0;
            rsp.sector_number       <= emit_sector;
            rsp.byte_count          <= emit_take;
            rsp.last_flag           <= remaining_next == 32'd0;
            rsp.status              <= fcc_pkg::STATUS_OK;
          end else if (accept && is_advance) begin
            if (walk_active) begin
              // table read issued this cycle; finish next cycle
              state <= ST_LOOKUP;
            end else begin
              rsp.sector_number <= '0;
              rsp.byte_count    <= '0;
              rsp.last_flag     <= 1'b0;
              rsp.status        <= fcc_pkg::STATUS_NO_WALK;
            end
          end
        end
        ST_LOOKUP: begin
          // output slot is free here: it was free or draining at accept
          state <= ST_IDLE;
          if (chain_broken) begin
            walk_active       <= 1'b0;
            rsp.sector_number <= '0;
            rsp.byte_count    <= '0;
            rsp.last_flag     <= 1'b1;
            rsp.status        <= fcc_pkg::STATUS_BROKEN;
          end else begin
            current_cluster   <= next_entry;
            bytes_remaining   <= remaining_next;
            walk_active       <= remaining_next != 32'd0;
            rsp.sector_number <= emit_sector;
            rsp.byte_count    <= emit_take;
            rsp.last_flag     <= remaining_next == 32'd0;
            rsp.status        <= fcc_pkg::STATUS_OK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/fat12_chain_checker.sv =====
// Scoreboard for the FAT12 cluster chain reader: watches the request, result
// and register ports, predicts every result and compares it field by field.
// Depends on fcc_pkg for the payload structs and the request/status codes.
module fat12_chain_checker #(
  parameter int TABLE_BYTES = 6144
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  fcc_pkg::req_t  req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  fcc_pkg::rsp_t  rsp,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  output int             fails,
  output int             pending,
  output int             n_ok,
  output int             n_no_walk,
  output int             n_broken,
  output int             n_last
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]    fat_copy [TABLE_BYTES];
  logic [11:0]   cluster_now;
  logic [31:0]   bytes_left;
  logic          walking;
  logic [15:0]   sector_base;
  fcc_pkg::rsp_t sector_queue [$];

  initial begin
    fails = 0;
    pending = 0;
    n_ok = 0;
    n_no_walk = 0;
    n_broken = 0;
    n_last = 0;
  end

  // Packed 12-bit entry: even clusters take the low nibble of the second byte,
  // odd clusters the high nibble of the first.
  function automatic logic [11:0] next_cluster(input logic [11:0] c);
    int         o;
    logic [7:0] lo, hi;
    o = (3 * int'(c)) / 2;
    lo = (o < TABLE_BYTES) ? fat_copy[o] : 8'h00;
    hi = (o + 1 < TABLE_BYTES) ? fat_copy[o + 1] : 8'h00;
    return c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
  endfunction

  // Consume the current cluster's share of the file and describe its sector.
  function automatic fcc_pkg::rsp_t take_sector();
    fcc_pkg::rsp_t s;
    logic [9:0]    share;
    share = (bytes_left < fcc_pkg::SECTOR_BYTES) ? bytes_left[9:0]
                                                 : 10'(fcc_pkg::SECTOR_BYTES);
    bytes_left -= 32'(share);
    walking = (bytes_left != 0);
    s.sector_number = 17'(cluster_now) + 17'(sector_base);
    s.byte_count = share;
    s.last_flag = !walking;
    s.status = fcc_pkg::STATUS_OK;
    return s;
  endfunction

  function automatic bit predict_sector(input fcc_pkg::req_t r, output fcc_pkg::rsp_t s);
    logic [11:0] nxt;
    s = '0;
    case (r.req_type)
      fcc_pkg::REQ_LOAD: begin
        if (r.byte_index < TABLE_BYTES) fat_copy[r.byte_index] = r.byte_value;
        return 1'b0;
      end
      fcc_pkg::REQ_START: begin
        cluster_now = r.start_cluster;
        bytes_left = r.file_size;
        s = take_sector();
        return 1'b1;
      end
      fcc_pkg::REQ_ADVANCE: begin
        if (!walking) begin
          s.status = fcc_pkg::STATUS_NO_WALK;
          return 1'b1;
        end
        nxt = next_cluster(cluster_now);
        if (nxt == fcc_pkg::FREE_ENTRY || nxt == fcc_pkg::BAD_ENTRY ||
            nxt >= fcc_pkg::END_FIRST) begin
          walking = 1'b0;
          s.last_flag = 1'b1;
          s.status = fcc_pkg::STATUS_BROKEN;
          return 1'b1;
        end
        cluster_now = nxt;
        s = take_sector();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_bad(input string what, input fcc_pkg::rsp_t got,
                            input fcc_pkg::rsp_t want);
    fails++;
    if (fails <= 10) begin
      $display("%t %s: got  sector %0d count %0d last %0d status %0d",
               $realtime, what, got.sector_number, got.byte_count, got.last_flag,
               got.status);
      $display("%t %s: want sector %0d count %0d last %0d status %0d",
               $realtime, what, want.sector_number, want.byte_count, want.last_flag,
               want.status);
    end
  endtask

  always @(posedge clk) begin
    fcc_pkg::rsp_t want, made;
    if (rst) begin
      cluster_now = '0;
      bytes_left = '0;
      walking = 1'b0;
      sector_base = fcc_pkg::OFFSET_RESET;
      sector_queue.delete();
    end else begin
      if (cfg_wr_en) sector_base = cfg_wr_data;
      // results first: one accepted on this edge cannot stem from this edge's request
      if (rsp_valid && rsp_ready) begin
        if (sector_queue.size() == 0) begin
          report_bad("result with nothing outstanding", rsp, '0);
        end else begin
          want = sector_queue.pop_front();
          if (rsp.sector_number !== want.sector_number ||
              rsp.byte_count !== want.byte_count ||
              rsp.last_flag !== want.last_flag ||
              rsp.status !== want.status)
            report_bad("result mismatch", rsp, want);
          case (want.status)
            fcc_pkg::STATUS_OK:      n_ok++;
            fcc_pkg::STATUS_NO_WALK: n_no_walk++;
            default:                 n_broken++;
          endcase
          if (want.last_flag) n_last++;
        end
      end
      if (req_valid && req_ready && predict_sector(req, made))
        sector_queue.push_back(made);
    end
    pending = sector_queue.size();
  end

endmodule

// ===== tb/fat12_cluster_chain_reader_unit_tb.sv =====
// Testbench top for fat12_cluster_chain_reader_unit: drives requests, offset
// writes and output backpressure, then gives the verdict.
// Depends on fcc_pkg, the unit itself and fat12_chain_checker.
module fat12_cluster_chain_reader_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TABLE_BYTES   = 6144;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;   // decoded by nobody, must be dropped
  localparam int         HOLD_CYCLES   = 400;
  localparam int         STALL_LIMIT   = 3000;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         PHASE_ITEMS   = 240;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  fcc_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  fcc_pkg::rsp_t rsp;
  logic          cfg_wr_en = 1'b0;
  logic [15:0]   cfg_wr_data = '0;

  int fails, pending, n_ok, n_no_walk, n_broken, n_last;

  // Stimulus-side copy of the table bytes, used to patch single entries
  // without disturbing the neighbor nibble.
  logic [7:0] plan_bytes [TABLE_BYTES];
  int         items_sent = 0;
  int         idle_cycles = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;
  bit         hold_req = 1'b0;

  always #5 clk = ~clk;

  fat12_cluster_chain_reader_unit #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fat12_chain_checker #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fails       (fails),
    .pending     (pending),
    .n_ok        (n_ok),
    .n_no_walk   (n_no_walk),
    .n_broken    (n_broken),
    .n_last      (n_last)
  );

  // Watchdog: end the run once neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[fat12_cluster_chain_reader_unit] ERROR");
      $finish;
    end
  end

  // Result side: after each result draw a random gap, maybe none, with ready low;
  // now and then switch to a stretch with no gaps at all. On request, hold
  // ready low for a long stretch so the unit backs up into its input.
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    rsp_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ready <= 1'b1;
        hold_req = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        gap = rx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          rsp_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  // Offer one request and return at the edge that accepts it. Valid is only
  // lowered when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_req(input fcc_pkg::req_t r);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (r.req_type == fcc_pkg::REQ_LOAD && r.byte_index < TABLE_BYTES)
      plan_bytes[r.byte_index] = r.byte_value;
    // dropped requests do no work and are not counted
    if (r.req_type != REQ_UNUSED &&
        !(r.req_type == fcc_pkg::REQ_LOAD && r.byte_index >= TABLE_BYTES))
      items_sent++;
  endtask

  // Unused fields carry random bits so the unit is seen to ignore them.
  function automatic fcc_pkg::req_t rand_req(input logic [1:0] kind);
    fcc_pkg::req_t r;
    r.req_type = kind;
    r.byte_index = 13'($urandom);
    r.byte_value = 8'($urandom);
    r.start_cluster = 12'($urandom);
    r.file_size = $urandom;
    return r;
  endfunction

  task automatic do_load(input logic [12:0] idx, input logic [7:0] val);
    fcc_pkg::req_t r;
    r = rand_req(fcc_pkg::REQ_LOAD);
    r.byte_index = idx;
    r.byte_value = val;
    send_req(r);
  endtask

  task automatic do_start(input logic [11:0] c, input logic [31:0] size);
    fcc_pkg::req_t r;
    r = rand_req(fcc_pkg::REQ_START);
    r.start_cluster = c;
    r.file_size = size;
    send_req(r);
  endtask

  task automatic do_advance();
    send_req(rand_req(fcc_pkg::REQ_ADVANCE));
  endtask

  // Write entry c = v as two byte loads, keeping the neighbor's nibble.
  task automatic set_entry(input logic [11:0] c, input logic [11:0] v);
    int         o;
    logic [7:0] b0, b1;
    o = (3 * int'(c)) / 2;
    b0 = plan_bytes[o];
    b1 = plan_bytes[o + 1];
    if (!c[0]) begin
      b0 = v[7:0];
      b1 = {b1[7:4], v[11:8]};
    end else begin
      b0 = {v[3:0], b0[3:0]};
      b1 = v[11:4];
    end
    do_load(13'(o), b0);
    do_load(13'(o + 1), b1);
  endtask

  // Drop valid, wait for every outstanding result, then let a trailing load
  // finish inside the unit.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic directed();
    // advance with no walk yet
    do_advance();
    // empty file: one result, byte count 0, walk never starts
    do_start(12'd0, 32'd0);
    // bad entry at the top of the table, then loads past its end that must
    // leave it alone; the file is as long as a size can be
    set_entry(12'hFFF, fcc_pkg::BAD_ENTRY);
    do_load(13'(TABLE_BYTES), 8'hFF);
    do_load(13'h1FFF, 8'h00);
    do_start(12'hFFF, 32'hFFFF_FFFF);
    do_advance();
    do_advance();
    // two full sectors, the chain ends right on the end-of-chain marker
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, fcc_pkg::END_FIRST);
    do_start(12'd2, 32'd1024);
    do_advance();
    do_advance();
    // one byte more than the chain holds: end of chain met early
    do_start(12'd2, 32'd1025);
    do_advance();
    do_advance();
    // a new start drops a live walk
    do_start(12'd2, 32'd513);
    do_start(12'd2, 32'd1);
    // free entry inside a walk
    set_entry(12'd5, fcc_pkg::FREE_ENTRY);
    do_start(12'd5, 32'd600);
    do_advance();
    // unknown request code with every field at its top
    send_req(fcc_pkg::req_t'{REQ_UNUSED, 13'h1FFF, 8'hFF, 12'hFFF, 32'hFFFF_FFFF});
  endtask

  task automatic noise_req();
    fcc_pkg::req_t r;
    case ($urandom_range(0, 3))
      0: begin
        // rewrite a byte with the value it already holds so no laid chain moves
        r = rand_req(fcc_pkg::REQ_LOAD);
        if (r.byte_index < TABLE_BYTES) r.byte_value = plan_bytes[r.byte_index];
      end
      1: r = rand_req(REQ_UNUSED);
      2: r = rand_req(fcc_pkg::REQ_ADVANCE);
      default: begin
        // one sector at most: the walk ends at once, so no later advance
        // follows a random cluster into bytes never loaded
        r = rand_req(fcc_pkg::REQ_START);
        r.file_size = $urandom_range(0, fcc_pkg::SECTOR_BYTES);
      end
    endcase
    send_req(r);
  endtask

  // Lay a chain of 1..6 distinct clusters into the table, close it with a
  // free, bad or end-of-chain entry, then walk it with a size that ends in the
  // last cluster, runs past the chain, or is zero.
  task automatic run_walk();
    logic [11:0] links [6];
    logic [11:0] term;
    logic [31:0] size;
    int          len, n_adv, i, j;
    bit          dup;
    len = $urandom_range(1, 6);
    links[0] = 12'($urandom);
    for (i = 1; i < len; i++) begin
      do begin
        links[i] = 12'($urandom_range(1, 32'hFF6));
        dup = 1'b0;
        for (j = 0; j < i; j++) if (links[j] == links[i]) dup = 1'b1;
      end while (dup);
    end
    case ($urandom_range(0, 3))
      0: term = fcc_pkg::FREE_ENTRY;
      1: term = fcc_pkg::BAD_ENTRY;
      default: term = 12'($urandom_range(fcc_pkg::END_FIRST, 12'hFFF));
    endcase
    for (i = 0; i + 1 < len; i++) set_entry(links[i], links[i + 1]);
    set_entry(links[len - 1], term);
    case ($urandom_range(0, 9))
      7, 8: begin
        size = 32'(len * fcc_pkg::SECTOR_BYTES + $urandom_range(1, 3000));
        n_adv = len;
      end
      9: begin
        size = 32'd0;
        n_adv = 0;
      end
      default: begin
        // the last share lands anywhere in 1..512, exact multiples included
        size = 32'((len - 1) * fcc_pkg::SECTOR_BYTES +
                   $urandom_range(1, fcc_pkg::SECTOR_BYTES));
        n_adv = len - 1;
      end
    endcase
    // abandon some walks early; the next start drops them
    if ($urandom_range(0, 7) == 0) n_adv = $urandom_range(0, n_adv);
    do_start(links[0], size);
    for (i = 0; i < n_adv; i++) begin
      if ($urandom_range(0, 9) == 0) noise_req();
      do_advance();
    end
    if ($urandom_range(0, 3) == 0) do_advance();
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) run_walk();
      else noise_req();
    end
  endtask

  initial begin
    logic [15:0] offsets [4];
    int          i, p;
    offsets = '{16'd0, 16'hFFFF, 16'($urandom), 16'($urandom)};
    // walks only read entries that set_entry loads; start the planning copy
    // at zero so the neighbor nibble of a first write is known
    for (i = 0; i < TABLE_BYTES; i++) plan_bytes[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    run_random(PHASE_ITEMS);
    // rerun the random walks under each sector offset, extremes first
    for (p = 0; p < 4; p++) begin
      settle();
      write_offset(offsets[p]);
      // starve the result side once while requests keep coming
      if (p == 1) hold_req = 1'b1;
      run_random(PHASE_ITEMS);
    end
    settle();
    $display("covered %0d requests: directed cases, random chain walks with noise",
             items_sent);
    $display("  offsets 31, 0, 65535, two random; %0d ok, %0d no walk, %0d broken, %0d last",
             n_ok, n_no_walk, n_broken, n_last);
    if (fails == 0 && pending == 0) begin
      $display("[fat12_cluster_chain_reader_unit] OK");
    end else begin
      $display("[fat12_cluster_chain_reader_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_table.sv
hw/rtl/fat12_cluster_chain_reader_unit.sv
tb/fat12_chain_checker.sv
tb/fat12_cluster_chain_reader_unit_tb.sv
